### design/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
// Used by pva_cell, pva_ctrl and poly_voice_allocator_top; depends on nothing.
`timescale 1ns / 1ps

package pva_pkg;

  // Default sizes, used as the defaults of the top level parameters.
  localparam int VOICES_DEF     = 6;
  localparam int STAMP_BITS_DEF = 32;

  // Field widths fixed by the interface.
  localparam int MODE_W   = 2;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 8;
  localparam int ENABLE_W = 6;
  localparam int VOICE_W  = 3;
  localparam int COUNT_W  = 3;
  localparam int CTRL_W   = 8;

  // Enable mask after reset: every voice may be allocated.
  localparam logic [ENABLE_W-1:0] ENABLE_RESET = 6'h3F;

  // Configuration register indexes.
  localparam logic REG_ENABLE = 1'b0;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Candidate classes, higher wins: a voice holding the same note, then a free voice,
  // then the oldest held voice.
  localparam logic [1:0] CLS_OLD   = 2'd0;
  localparam logic [1:0] CLS_FREE  = 2'd1;
  localparam logic [1:0] CLS_MATCH = 2'd2;

  // Volume: round(vel * 31 / 255) = (62 * vel + 255) / 510, the division done by a
  // reciprocal multiply that is exact for every numerator below 2^23 / 382.
  localparam int VOL_NUM_W  = 14;
  localparam int VOL_PROD_W = 29;
  localparam logic [VOL_NUM_W-1:0]  VOL_MUL   = 14'd62;
  localparam logic [VOL_NUM_W-1:0]  VOL_BIAS  = 14'd255;
  localparam logic [VOL_PROD_W-1:0] VOL_RECIP = 29'd16449;
  localparam int VOL_SHIFT = 23;
  localparam logic [5:0] VOL_MIN = 6'd1;
  localparam logic [5:0] VOL_MAX = 6'd31;
  localparam logic [CTRL_W-1:0] CTRL_ON = 8'h80;

  // Search token flags that travel down the chain of voice cells.
  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
    logic [NOTE_W-1:0] note;
    logic              found;
    logic [1:0]        cls;
  } tok_t;

  // Update command broadcast to every cell once the search is complete.
  typedef struct packed {
    logic              apply;
    logic [MODE_W-1:0] mode;
    logic [NOTE_W-1:0] note;
    logic              grant;
  } cmd_t;

endpackage

### design/poly_voice_allocator_top.sv
// Polyphonic voice allocator: the search token of an accepted request walks the chain
// of voice cells one per cycle, and the result register is loaded once it leaves the tail.
// Requests are searched one at a time: the next is taken once the last has been applied.
// A request is taken while an earlier result still waits in the output register.
// Synchronous reset frees every voice, restarts the stamp counter and enables all voices.
// Top level: APB register, cell chain and sequencer. Depends on pva_pkg, pva_cell, pva_ctrl.
`timescale 1ns / 1ps

module poly_voice_allocator_top #(
  parameter int VOICES     = pva_pkg::VOICES_DEF,
  parameter int STAMP_BITS = pva_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Event requests
  input  logic                          evt_valid,
  output logic                          evt_stall,
  input  logic [pva_pkg::MODE_W-1:0]    mode,
  input  logic [pva_pkg::NOTE_W-1:0]    note,
  input  logic [pva_pkg::VEL_W-1:0]     velocity,
  // Results
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          assigned,
  output logic [pva_pkg::VOICE_W-1:0]   voice,
  output logic [pva_pkg::CTRL_W-1:0]    voice_control,
  output logic [pva_pkg::ENABLE_W-1:0]  released_mask,
  output logic [pva_pkg::COUNT_W-1:0]   active_count,
  output logic                          any_active
);

  localparam int IW = $clog2(VOICES);
  localparam int CW = $clog2(VOICES + 1);

  logic [pva_pkg::ENABLE_W-1:0]        voice_enable_mask;
  logic [VOICES+pva_pkg::ENABLE_W-1:0] enable_ext;

  // Chain links: entry 0 is the head, entry VOICES the tail.
  pva_pkg::tok_t         tok_c   [VOICES+1];
  logic [IW-1:0]         idx_c   [VOICES+1];
  logic [STAMP_BITS-1:0] stamp_c [VOICES+1];
  logic [VOICES-1:0]     rel_c   [VOICES+1];
  logic [CW-1:0]         act_c   [VOICES+1];
  logic [CW-1:0]         keep_c  [VOICES+1];

  pva_pkg::cmd_t         cmd;
  logic [VOICES-1:0]     sel;
  logic [STAMP_BITS-1:0] new_stamp;

  // Configuration register: writes complete in the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_enable_mask <= pva_pkg::ENABLE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == pva_pkg::REG_ENABLE)) begin
      voice_enable_mask <= pwdata[pva_pkg::ENABLE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == pva_pkg::REG_ENABLE) ? 32'(voice_enable_mask) : '0;

  // Voices beyond the register width are never enabled.
  assign enable_ext = {{VOICES{1'b0}}, voice_enable_mask};

  // Head of the chain: a fresh token for each accepted request.
  always_comb begin
    tok_c[0].valid = evt_valid && !evt_stall;
    tok_c[0].mode  = mode;
    tok_c[0].note  = note;
    tok_c[0].found = 1'b0;
    tok_c[0].cls   = pva_pkg::CLS_OLD;
    idx_c[0]       = '0;
    stamp_c[0]     = '0;
    rel_c[0]       = '0;
    act_c[0]       = '0;
    keep_c[0]      = '0;
  end

  // Chain of voice cells.
  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    pva_cell #(
      .VOICES     (VOICES),
      .STAMP_BITS (STAMP_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (enable_ext[i]),
      .tok_in    (tok_c[i]),
      .idx_in    (idx_c[i]),
      .stamp_in  (stamp_c[i]),
      .rel_in    (rel_c[i]),
      .act_in    (act_c[i]),
      .keep_in   (keep_c[i]),
      .tok_out   (tok_c[i+1]),
      .idx_out   (idx_c[i+1]),
      .stamp_out (stamp_c[i+1]),
      .rel_out   (rel_c[i+1]),
      .act_out   (act_c[i+1]),
      .keep_out  (keep_c[i+1]),
      .cmd       (cmd),
      .sel       (sel[i]),
      .new_stamp (new_stamp)
    );
  end

  // Sequencer and result register.
  pva_ctrl #(
    .VOICES     (VOICES),
    .STAMP_BITS (STAMP_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .evt_valid     (evt_valid),
    .evt_stall     (evt_stall),
    .velocity      (velocity),
    .tail          (tok_c[VOICES]),
    .tail_idx      (idx_c[VOICES]),
    .tail_rel      (rel_c[VOICES]),
    .tail_act      (act_c[VOICES]),
    .tail_keep     (keep_c[VOICES]),
    .cmd           (cmd),
    .sel           (sel),
    .new_stamp     (new_stamp),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .assigned      (assigned),
    .voice         (voice),
    .voice_control (voice_control),
    .released_mask (released_mask),
    .active_count  (active_count),
    .any_active    (any_active)
  );

endmodule

### design/pva_cell.sv
// One voice cell: holds the note and start stamp of one voice, folds its own state
// into the search token and hands it on. Depends on pva_pkg.
`timescale 1ns / 1ps

module pva_cell #(
  parameter int VOICES     = pva_pkg::VOICES_DEF,
  parameter int STAMP_BITS = pva_pkg::STAMP_BITS_DEF,
  parameter int INDEX      = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  pva_pkg::tok_t                tok_in,
  input  logic [$clog2(VOICES)-1:0]    idx_in,
  input  logic [STAMP_BITS-1:0]        stamp_in,
  input  logic [VOICES-1:0]            rel_in,
  input  logic [$clog2(VOICES+1)-1:0]  act_in,
  input  logic [$clog2(VOICES+1)-1:0]  keep_in,
  output pva_pkg::tok_t                tok_out,
  output logic [$clog2(VOICES)-1:0]    idx_out,
  output logic [STAMP_BITS-1:0]        stamp_out,
  output logic [VOICES-1:0]            rel_out,
  output logic [$clog2(VOICES+1)-1:0]  act_out,
  output logic [$clog2(VOICES+1)-1:0]  keep_out,
  input  pva_pkg::cmd_t                cmd,
  input  logic                         sel,
  input  logic [STAMP_BITS-1:0]        new_stamp
);

  localparam int IW = $clog2(VOICES);
  localparam int CW = $clog2(VOICES + 1);

  // Voice state.
  logic                       held;
  logic [pva_pkg::NOTE_W-1:0] voice_note;
  logic [STAMP_BITS-1:0]      voice_stamp;

  // Search step.
  logic                hit;
  logic [1:0]          my_cls;
  logic                take;
  logic                rel;
  pva_pkg::tok_t       tok_next;
  logic [IW-1:0]       idx_next;
  logic [STAMP_BITS-1:0] stamp_next;
  logic [VOICES-1:0]   rel_next;
  logic [CW-1:0]       act_next;
  logic [CW-1:0]       keep_next;

  // Compare this voice against the best so far; an enabled voice wins if none was
  // found yet, on a higher class or, among held voices, on a strictly older stamp.
  always_comb begin
    hit = held && (voice_note == tok_in.note);
    if (hit) begin
      my_cls = pva_pkg::CLS_MATCH;
    end else if (held) begin
      my_cls = pva_pkg::CLS_OLD;
    end else begin
      my_cls = pva_pkg::CLS_FREE;
    end
    take = en && (!tok_in.found || (my_cls > tok_in.cls) ||
                  ((my_cls == pva_pkg::CLS_OLD) && (tok_in.cls == pva_pkg::CLS_OLD) &&
                   (voice_stamp < stamp_in)));
    rel = held && ((tok_in.mode == pva_pkg::MODE_CLEAR) || hit);

    tok_next       = tok_in;
    tok_next.found = tok_in.found || en;
    tok_next.cls   = take ? my_cls : tok_in.cls;
    idx_next       = take ? IW'(INDEX) : idx_in;
    stamp_next     = take ? voice_stamp : stamp_in;
    rel_next       = rel_in | (VOICES'(rel) << INDEX);
    act_next       = act_in + CW'(en && held);
    keep_next      = keep_in + CW'(en && held && !hit);
  end

  // Token stage: valid is control, the rest is held until the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    if (tok_in.valid) begin
      tok_out.mode  <= tok_next.mode;
      tok_out.note  <= tok_next.note;
      tok_out.found <= tok_next.found;
      tok_out.cls   <= tok_next.cls;
      idx_out       <= idx_next;
      stamp_out     <= stamp_next;
      rel_out       <= rel_next;
      act_out       <= act_next;
      keep_out      <= keep_next;
    end
  end

  // Voice update from the broadcast command.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd.apply) begin
      unique case (cmd.mode)
        pva_pkg::MODE_ON: begin
          if (cmd.grant && sel) begin
            held <= 1'b1;
          end
        end
        pva_pkg::MODE_OFF: begin
          if (held && (voice_note == cmd.note)) begin
            held <= 1'b0;
          end
        end
        pva_pkg::MODE_CLEAR: begin
          held <= 1'b0;
        end
        default: begin
          held <= held;
        end
      endcase
    end
  end

  // Note and stamp are only looked at while the voice is held.
  always_ff @(posedge clk) begin
    if (cmd.apply && (cmd.mode == pva_pkg::MODE_ON) && cmd.grant && sel) begin
      voice_note  <= cmd.note;
      voice_stamp <= new_stamp;
    end
  end

endmodule

### design/pva_ctrl.sv
// Request sequencer: accepts events, waits for the search token to leave the chain,
// issues the update command and holds the result register. Depends on pva_pkg.
`timescale 1ns / 1ps

module pva_ctrl #(
  parameter int VOICES     = pva_pkg::VOICES_DEF,
  parameter int STAMP_BITS = pva_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          evt_valid,
  output logic                          evt_stall,
  input  logic [pva_pkg::VEL_W-1:0]     velocity,
  input  pva_pkg::tok_t                 tail,
  input  logic [$clog2(VOICES)-1:0]     tail_idx,
  input  logic [VOICES-1:0]             tail_rel,
  input  logic [$clog2(VOICES+1)-1:0]   tail_act,
  input  logic [$clog2(VOICES+1)-1:0]   tail_keep,
  output pva_pkg::cmd_t                 cmd,
  output logic [VOICES-1:0]             sel,
  output logic [STAMP_BITS-1:0]         new_stamp,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          assigned,
  output logic [pva_pkg::VOICE_W-1:0]   voice,
  output logic [pva_pkg::CTRL_W-1:0]    voice_control,
  output logic [pva_pkg::ENABLE_W-1:0]  released_mask,
  output logic [pva_pkg::COUNT_W-1:0]   active_count,
  output logic                          any_active
);

  localparam int IW = $clog2(VOICES);
  localparam int CW = $clog2(VOICES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [pva_pkg::VEL_W-1:0]   vel_q;
  logic [STAMP_BITS-1:0]       stamp_counter;

  logic                        out_free;
  logic                        finish;
  logic                        apply;
  logic                        grant;
  logic [pva_pkg::VOL_NUM_W-1:0]  vol_num;
  logic [pva_pkg::VOL_PROD_W-1:0] vol_prod;
  logic [5:0]                  vol_raw;
  logic [5:0]                  vol;
  logic [CW-1:0]               act_after;
  logic [IW+pva_pkg::VOICE_W-1:0]    idx_ext;
  logic [VOICES+pva_pkg::ENABLE_W-1:0] rel_ext;
  logic [CW+pva_pkg::COUNT_W-1:0]    act_ext;

  // Handshake and sequencing.
  assign evt_stall = (state != ST_IDLE);
  assign out_free  = !res_valid || !res_stall;
  assign finish    = ((state == ST_SEARCH) && tail.valid) || (state == ST_WAIT);
  assign apply     = finish && out_free;
  assign grant     = (tail.mode == pva_pkg::MODE_ON) && tail.found;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (evt_valid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail.valid) begin
          state_next = out_free ? ST_IDLE : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Velocity is needed only at the end of the search.
  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      vel_q <= velocity;
    end
  end

  // Update command for the voice cells.
  always_comb begin
    cmd.apply = apply;
    cmd.mode  = tail.mode;
    cmd.note  = tail.note;
    cmd.grant = grant;
    sel       = VOICES'(1) << tail_idx;
    new_stamp = stamp_counter + STAMP_BITS'(1);
  end

  // Stamp counter: advances on every grant, restarts on clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
    end else if (apply) begin
      if (tail.mode == pva_pkg::MODE_CLEAR) begin
        stamp_counter <= '0;
      end else if (grant) begin
        stamp_counter <= new_stamp;
      end
    end
  end

  // Volume from velocity, rounded and clamped to 1..31.
  always_comb begin
    vol_num  = (pva_pkg::VOL_NUM_W'(vel_q) * pva_pkg::VOL_MUL) + pva_pkg::VOL_BIAS;
    vol_prod = pva_pkg::VOL_PROD_W'(vol_num) * pva_pkg::VOL_RECIP;
    vol_raw  = vol_prod[pva_pkg::VOL_SHIFT +: 6];
    if (vol_raw < pva_pkg::VOL_MIN) begin
      vol = pva_pkg::VOL_MIN;
    end else if (vol_raw > pva_pkg::VOL_MAX) begin
      vol = pva_pkg::VOL_MAX;
    end else begin
      vol = vol_raw;
    end
  end

  // Enabled voices holding a note once this request has taken effect.
  always_comb begin
    unique case (tail.mode)
      pva_pkg::MODE_ON: begin
        act_after = (grant && (tail.cls == pva_pkg::CLS_FREE)) ?
                    tail_act + CW'(1) : tail_act;
      end
      pva_pkg::MODE_OFF: begin
        act_after = tail_keep;
      end
      pva_pkg::MODE_CLEAR: begin
        act_after = '0;
      end
      default: begin
        act_after = tail_act;
      end
    endcase
    idx_ext = {{pva_pkg::VOICE_W{1'b0}}, tail_idx};
    rel_ext = {{pva_pkg::ENABLE_W{1'b0}}, tail_rel};
    act_ext = {{pva_pkg::COUNT_W{1'b0}}, act_after};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (apply) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      assigned      <= grant;
      voice         <= grant ? idx_ext[pva_pkg::VOICE_W-1:0] : '0;
      voice_control <= grant ? (pva_pkg::CTRL_ON | pva_pkg::CTRL_W'(vol)) : '0;
      released_mask <= ((tail.mode == pva_pkg::MODE_OFF) ||
                        (tail.mode == pva_pkg::MODE_CLEAR)) ?
                       rel_ext[pva_pkg::ENABLE_W-1:0] : '0;
      active_count  <= act_ext[pva_pkg::COUNT_W-1:0];
      any_active    <= (act_after != '0);
    end
  end

endmodule

### verif/tb_top.sv
// Self-checking testbench for poly_voice_allocator_top: directed and random note events
// are checked against an in-bench model of the allocator. Depends on pva_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int NV = pva_pkg::VOICES_DEF;
  localparam logic [pva_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_ENABLE = {pva_pkg::REG_ENABLE, 2'b00};
  localparam int EXP_DEPTH = 16;

  // One expected result of the allocator.
  typedef struct packed {
    logic                         assigned;
    logic [pva_pkg::VOICE_W-1:0]  voice;
    logic [pva_pkg::CTRL_W-1:0]   ctrl;
    logic [pva_pkg::ENABLE_W-1:0] released;
    logic [pva_pkg::COUNT_W-1:0]  count;
    logic                         any;
  } alloc_result_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic evt_valid, evt_stall;
  logic [pva_pkg::MODE_W-1:0] mode;
  logic [pva_pkg::NOTE_W-1:0] note;
  logic [pva_pkg::VEL_W-1:0] velocity;
  logic res_valid, res_stall;
  logic assigned;
  logic [pva_pkg::VOICE_W-1:0] voice;
  logic [pva_pkg::CTRL_W-1:0] voice_control;
  logic [pva_pkg::ENABLE_W-1:0] released_mask;
  logic [pva_pkg::COUNT_W-1:0] active_count;
  logic any_active;

  // Allocator model state.
  logic [7:0]                   held_note [NV];
  logic [31:0]                  start_stamp [NV];
  logic [31:0]                  stamp_count;
  logic [pva_pkg::ENABLE_W-1:0] enable_mask;

  // Expected results in request order: a ring with write and read counts.
  alloc_result_t exp_ring [EXP_DEPTH];
  int exp_wr;
  int exp_rd;
  int mismatch_count;
  int sender_idle_pct;
  int stall_pct;

  poly_voice_allocator_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .evt_valid(evt_valid), .evt_stall(evt_stall),
    .mode(mode), .note(note), .velocity(velocity),
    .res_valid(res_valid), .res_stall(res_stall),
    .assigned(assigned), .voice(voice), .voice_control(voice_control),
    .released_mask(released_mask), .active_count(active_count), .any_active(any_active)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Appends one expected result to the ring.
  task automatic store_expected(input alloc_result_t r);
    exp_ring[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endtask

  // Works out the result of one event and updates the model state.
  task automatic predict_allocation(input logic [pva_pkg::MODE_W-1:0] m,
                                    input logic [pva_pkg::NOTE_W-1:0] n,
                                    input logic [pva_pkg::VEL_W-1:0] vel);
    alloc_result_t r;
    int pick;
    int vol;
    int cnt;
    r = '0;
    pick = -1;
    cnt = 0;
    if (m == pva_pkg::MODE_ON) begin
      // Same note first, then the lowest free voice, then the oldest stamp.
      for (int v = 0; v < NV; v++)
        if (pick < 0 && enable_mask[v] && held_note[v][7] && held_note[v][6:0] == n)
          pick = v;
      for (int v = 0; v < NV; v++)
        if (pick < 0 && enable_mask[v] && !held_note[v][7]) pick = v;
      if (pick < 0) begin
        for (int v = 0; v < NV; v++)
          if (enable_mask[v] && (pick < 0 || start_stamp[v] < start_stamp[pick])) pick = v;
      end
      if (pick >= 0) begin
        vol = (62 * int'(vel) + 255) / 510;
        if (vol < int'(pva_pkg::VOL_MIN)) vol = int'(pva_pkg::VOL_MIN);
        if (vol > int'(pva_pkg::VOL_MAX)) vol = int'(pva_pkg::VOL_MAX);
        stamp_count = stamp_count + 32'd1;
        held_note[pick] = {1'b1, n};
        start_stamp[pick] = stamp_count;
        r.assigned = 1'b1;
        r.voice = pick[pva_pkg::VOICE_W-1:0];
        r.ctrl = pva_pkg::CTRL_ON | vol[pva_pkg::CTRL_W-1:0];
      end
    end else if (m == pva_pkg::MODE_OFF) begin
      // Frees matching voices, enabled or not.
      for (int v = 0; v < NV; v++)
        if (held_note[v][7] && held_note[v][6:0] == n) begin
          held_note[v] = '0;
          start_stamp[v] = '0;
          r.released[v] = 1'b1;
        end
    end else if (m == pva_pkg::MODE_CLEAR) begin
      for (int v = 0; v < NV; v++) begin
        r.released[v] = held_note[v][7];
        held_note[v] = '0;
        start_stamp[v] = '0;
      end
      stamp_count = '0;
    end
    for (int v = 0; v < NV; v++)
      if (enable_mask[v] && held_note[v][7]) cnt++;
    r.count = cnt[pva_pkg::COUNT_W-1:0];
    r.any = (cnt > 0);
    store_expected(r);
  endtask

  // Sends one event request; called at a falling edge, returns at a falling edge.
  task automatic send_event(input logic [pva_pkg::MODE_W-1:0] m,
                            input logic [pva_pkg::NOTE_W-1:0] n,
                            input logic [pva_pkg::VEL_W-1:0] vel);
    if ($urandom_range(99) < sender_idle_pct) begin
      evt_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    evt_valid <= 1'b1;
    mode <= m;
    note <= n;
    velocity <= vel;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    predict_allocation(m, n, vel);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every expected result has been taken.
  task automatic wait_idle();
    evt_valid <= 1'b0;
    @(negedge clk);
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (NV + 2) @(negedge clk);
  endtask

  // APB write of the enable register, only while the block is idle.
  task automatic write_enable(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ENABLE;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    enable_mask = value[pva_pkg::ENABLE_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // APB read of the enable register, compared with the model.
  task automatic check_enable_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_ENABLE;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[pva_pkg::ENABLE_W-1:0] !== enable_mask)
      report_mismatch($sformatf("enable readback got %0h expected %0h",
                                prdata[pva_pkg::ENABLE_W-1:0], enable_mask));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver stall, redrawn every cycle.
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst && res_valid && !res_stall) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp_r = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (assigned !== exp_r.assigned)
          report_mismatch($sformatf("assigned got %0h expected %0h",
                                    assigned, exp_r.assigned));
        if (voice !== exp_r.voice)
          report_mismatch($sformatf("voice got %0h expected %0h", voice, exp_r.voice));
        if (voice_control !== exp_r.ctrl)
          report_mismatch($sformatf("voice_control got %0h expected %0h",
                                    voice_control, exp_r.ctrl));
        if (released_mask !== exp_r.released)
          report_mismatch($sformatf("released_mask got %0h expected %0h",
                                    released_mask, exp_r.released));
        if (active_count !== exp_r.count)
          report_mismatch($sformatf("active_count got %0h expected %0h",
                                    active_count, exp_r.count));
        if (any_active !== exp_r.any)
          report_mismatch($sformatf("any_active got %0h expected %0h",
                                    any_active, exp_r.any));
      end
    end
  end

  // Enable register comes out of reset with every voice enabled.
  task automatic test_reset_register();
    check_enable_readback();
  endtask

  // Fills all voices, covering note and velocity extremes and volume rounding.
  task automatic test_fill_and_volume();
    send_event(pva_pkg::MODE_ON, 7'd0, 8'd0);
    send_event(pva_pkg::MODE_ON, 7'd127, 8'd255);
    send_event(pva_pkg::MODE_ON, 7'd60, 8'd1);
    send_event(pva_pkg::MODE_ON, 7'd61, 8'd13);
    send_event(pva_pkg::MODE_ON, 7'd62, 8'd128);
    send_event(pva_pkg::MODE_ON, 7'd63, 8'd9);
  endtask

  // A held note retriggers in place; then the oldest voices are stolen.
  task automatic test_retrigger_and_steal();
    send_event(pva_pkg::MODE_ON, 7'd60, 8'd200);
    send_event(pva_pkg::MODE_ON, 7'd100, 8'd77);
    send_event(pva_pkg::MODE_ON, 7'd101, 8'd254);
  endtask

  // Note-off of a held note and of an absent one, then refill of the freed voice.
  task automatic test_note_off();
    send_event(pva_pkg::MODE_OFF, 7'd60, 8'd0);
    send_event(pva_pkg::MODE_OFF, 7'd5, 8'hAA);
    send_event(pva_pkg::MODE_ON, 7'd42, 8'd55);
  endtask

  // Disabled voices: still released by note-off, never allocated or counted.
  task automatic test_disabled_voices();
    wait_idle();
    write_enable(32'hA5A5_A5CF);
    check_enable_readback();
    send_event(pva_pkg::MODE_OFF, 7'd63, 8'd0);
    send_event(pva_pkg::MODE_ON, 7'd63, 8'd100);
  endtask

  // No enabled voice: note-on assigns nothing, note-off still frees.
  task automatic test_no_enabled_voice();
    wait_idle();
    write_enable(32'h0);
    send_event(pva_pkg::MODE_ON, 7'd10, 8'd50);
    send_event(pva_pkg::MODE_OFF, 7'd62, 8'd0);
  endtask

  // The unused mode changes nothing and only reports the count.
  task automatic test_unused_mode();
    wait_idle();
    write_enable(32'h3F);
    send_event(MODE_UNUSED, 7'd127, 8'hFF);
  endtask

  // Clear with voices held, clear when empty, and a note-on after the restart.
  task automatic test_clear();
    send_event(pva_pkg::MODE_CLEAR, 7'd0, 8'd0);
    send_event(pva_pkg::MODE_CLEAR, 7'd33, 8'd0);
    send_event(pva_pkg::MODE_ON, 7'd64, 8'd31);
  endtask

  // Random traffic in chunks, each under its own enable mask.
  task automatic test_random_traffic(input int phase, input int items_per_chunk);
    logic [pva_pkg::NOTE_W-1:0] pool [8];
    logic [pva_pkg::NOTE_W-1:0] held_list [NV];
    int held_cnt;
    logic [pva_pkg::NOTE_W-1:0] n;
    logic [pva_pkg::MODE_W-1:0] m;
    logic [31:0] mask_val;
    int sel;
    for (int i = 0; i < 8; i++) pool[i] = $urandom_range(127);
    for (int chunk = 0; chunk < 4; chunk++) begin
      wait_idle();
      case (chunk)
        0: mask_val = 32'h3F;
        1: mask_val = $urandom_range(1, 62);
        2: mask_val = (phase == 0) ? 32'h01 : (phase == 1) ? 32'h20 : 32'h00;
        default: mask_val = $urandom;
      endcase
      write_enable(mask_val);
      for (int k = 0; k < items_per_chunk; k++) begin
        sel = $urandom_range(99);
        n = pool[$urandom_range(7)];
        if (sel < 55) begin
          m = pva_pkg::MODE_ON;
        end else if (sel < 85) begin
          // When some voice holds a note, release one of the held notes half the time.
          m = pva_pkg::MODE_OFF;
          held_cnt = 0;
          for (int v = 0; v < NV; v++)
            if (held_note[v][7]) begin
              held_list[held_cnt] = held_note[v][6:0];
              held_cnt++;
            end
          if (held_cnt != 0 && $urandom_range(1))
            n = held_list[$urandom_range(held_cnt - 1)];
        end else if (sel < 91) begin
          m = pva_pkg::MODE_CLEAR;
        end else if (sel < 95) begin
          m = MODE_UNUSED;
        end else begin
          m = pva_pkg::MODE_ON;
          n = $urandom_range(127);
        end
        send_event(m, n, $urandom_range(255));
      end
    end
  endtask

  // Main sequence.
  initial begin
    int waited;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    evt_valid = 1'b0;
    mode = '0;
    note = '0;
    velocity = '0;
    res_stall = 1'b0;
    exp_wr = 0;
    exp_rd = 0;
    mismatch_count = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    enable_mask = pva_pkg::ENABLE_RESET;
    stamp_count = '0;
    for (int v = 0; v < NV; v++) begin
      held_note[v] = '0;
      start_stamp[v] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_register();
    sender_idle_pct = 23;
    stall_pct = 87;
    test_fill_and_volume();
    test_retrigger_and_steal();
    test_note_off();
    test_disabled_voices();
    test_no_enabled_voice();
    test_unused_mode();
    test_clear();

    sender_idle_pct = 23;
    stall_pct = 87;
    test_random_traffic(0, 71);
    sender_idle_pct = 87;
    stall_pct = 23;
    test_random_traffic(1, 71);
    sender_idle_pct = 0;
    stall_pct = 0;
    test_random_traffic(2, 71);

    // Drain, then allow the pipeline to settle.
    evt_valid <= 1'b0;
    waited = 0;
    while (exp_wr != exp_rd && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (2 * NV + 4) @(negedge clk);
    if (exp_wr != exp_rd)
      report_mismatch($sformatf("%0d expected results never arrived", exp_wr - exp_rd));

    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
